[hw/rtl/psfd_pkg.sv]
// psfd_pkg: beat types, entry record, status/action codes and fsm states
// for the per-source flood detector; no dependencies

package psfd_pkg;

    // fixed field widths
    localparam int unsigned IDX_W    = 8;
    localparam int unsigned SEC_W    = 32;
    localparam int unsigned CNT_W    = 32;
    localparam int unsigned PTR_W    = 6;
    localparam int unsigned WINDOW_W = 16;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd3;

    typedef enum logic [1:0] {
        ST_CLEAR    = 2'd0,
        ST_REJECTED = 2'd1,
        ST_DROPPED  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ACT_NONE     = 2'd0,
        ACT_REJECTED = 2'd1,
        ACT_DROPPED  = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_HIST,
        FSM_UPDATE
    } fsm_t;

    typedef struct packed {
        logic [IDX_W-1:0] entry_index;
        logic [SEC_W-1:0] arrival_sec;
        logic             drop_allowed;
    } in_beat_t;

    typedef struct packed {
        action_t          action;
        status_t          entry_status;
        logic [CNT_W-1:0] packet_count;
    } out_beat_t;

    // per-source record held in the entry store
    typedef struct packed {
        logic [PTR_W-1:0] ptr;
        status_t          status;
        logic [CNT_W-1:0] count;
    } entry_rec_t;

    // control from the sequencer to a memory
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

endpackage

[hw/rtl/psfd_entry_store.sv]
// psfd_entry_store: per-source record memory (pointer, status, count) with
// one valid bit per entry so unwritten entries read as zero; uses psfd_pkg

module psfd_entry_store #(
    parameter int unsigned NUM_ENTRIES = 256,
    parameter int unsigned AW          = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  psfd_pkg::mem_ctl_t   ctl,
    input  logic [AW-1:0]        rd_addr,
    input  logic [AW-1:0]        wr_addr,
    input  psfd_pkg::entry_rec_t wr_data,
    output psfd_pkg::entry_rec_t rd_data
);

    psfd_pkg::entry_rec_t mem [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] valid_reg;
    psfd_pkg::entry_rec_t   rd_data_reg;
    logic                   rd_valid_reg;

    // record array, registered read
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // valid bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // never-written entry reads as the reset record
    assign rd_data = rd_valid_reg ? rd_data_reg : psfd_pkg::entry_rec_t'('0);

endmodule

[hw/rtl/psfd_hist_ram.sv]
// psfd_hist_ram: arrival-second history ring storage, one write and one
// read port, registered read; uses psfd_pkg for control and widths

module psfd_hist_ram #(
    parameter int unsigned DEPTH = 12800,
    parameter int unsigned AW    = 14
) (
    input  logic                          clk,
    input  psfd_pkg::mem_ctl_t            ctl,
    input  logic [AW-1:0]                 rd_addr,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [psfd_pkg::SEC_W-1:0]    wr_data,
    output logic [psfd_pkg::SEC_W-1:0]    rd_data
);

    logic [psfd_pkg::SEC_W-1:0] mem [DEPTH];
    logic [psfd_pkg::SEC_W-1:0] rd_data_reg;

    // write and read in one clocked block
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/per_source_flood_detector.sv]
// per_source_flood_detector: one beat at a time, set by the record read,
// history read and write-back sequence through the two memories.
// the result is registered onto out_valid together with the write-back, which waits
// while out has no room; the next beat is taken only after that write-back.
// reset: window is 3, entry valid bits clear; history slots are qualified by
// packet count, so no clearing pass; uses psfd_pkg, psfd_entry_store, psfd_hist_ram

module per_source_flood_detector #(
    parameter int unsigned NUM_ENTRIES   = 256,
    parameter int unsigned HISTORY_DEPTH = 50
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              window_wr_en,
    input  logic [psfd_pkg::WINDOW_W-1:0]     window_wr_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  psfd_pkg::in_beat_t                in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output psfd_pkg::out_beat_t               out_data
);

    localparam int unsigned ENTRY_AW   = $clog2(NUM_ENTRIES);
    localparam int unsigned HIST_DEPTH = NUM_ENTRIES * HISTORY_DEPTH;
    localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);
    localparam logic [psfd_pkg::PTR_W-1:0] PTR_LAST =
        psfd_pkg::PTR_W'(HISTORY_DEPTH - 1);

    psfd_pkg::fsm_t state_reg, state_next;

    logic [psfd_pkg::WINDOW_W-1:0] window_reg;

    // beat held while it is worked on
    logic [ENTRY_AW-1:0]        idx_reg;
    logic [psfd_pkg::SEC_W-1:0] now_reg;
    logic                       drop_reg;
    logic                       in_range_reg;

    // record and slot state carried into the update cycle
    psfd_pkg::entry_rec_t       rec_reg;
    logic [psfd_pkg::PTR_W-1:0] nxt_reg;
    logic                       old_valid_reg;

    logic                 out_valid_reg;
    psfd_pkg::out_beat_t  out_data_reg;

    psfd_pkg::mem_ctl_t   entry_ctl, hist_ctl;
    psfd_pkg::entry_rec_t entry_rd, entry_wr;
    logic [psfd_pkg::SEC_W-1:0] hist_rd;
    logic [HIST_AW-1:0]   hist_base, hist_wr_addr, hist_rd_addr;
    logic [psfd_pkg::PTR_W-1:0] nxt;
    logic                 accept, out_free, out_load;
    logic                 in_range;

    logic [psfd_pkg::SEC_W-1:0] old_sec;
    logic [psfd_pkg::SEC_W:0]   diff;
    logic                       flood;
    psfd_pkg::status_t          status_new;
    psfd_pkg::action_t          action_new;
    logic [psfd_pkg::CNT_W-1:0] count_new;

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_range = {1'b0, in_data.entry_index} < (psfd_pkg::IDX_W + 1)'(NUM_ENTRIES);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            psfd_pkg::FSM_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = psfd_pkg::FSM_HIST;
                end
            end
            psfd_pkg::FSM_HIST:
            begin
                state_next = psfd_pkg::FSM_UPDATE;
            end
            psfd_pkg::FSM_UPDATE:
            begin
                if (out_free)
                begin
                    state_next = psfd_pkg::FSM_IDLE;
                end
            end
            default:
            begin
                state_next = psfd_pkg::FSM_IDLE;
            end
        endcase
    end

    // fsm outputs
    always_comb
    begin
        in_stall        = 1'b1;
        entry_ctl.rd_en = 1'b0;
        entry_ctl.wr_en = 1'b0;
        hist_ctl.rd_en  = 1'b0;
        hist_ctl.wr_en  = 1'b0;
        out_load        = 1'b0;
        unique case (state_reg)
            psfd_pkg::FSM_IDLE:
            begin
                in_stall        = 1'b0;
                entry_ctl.rd_en = in_valid;
            end
            psfd_pkg::FSM_HIST:
            begin
                hist_ctl.rd_en = in_range_reg;
                hist_ctl.wr_en = in_range_reg;
            end
            psfd_pkg::FSM_UPDATE:
            begin
                out_load        = out_free;
                entry_ctl.wr_en = out_free && in_range_reg;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= psfd_pkg::FSM_IDLE;
            window_reg    <= psfd_pkg::WINDOW_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (window_wr_en)
            begin
                window_reg <= window_wr_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ring slot after the write pointer
    assign nxt = (entry_rd.ptr == PTR_LAST) ? '0 : entry_rd.ptr + 1'b1;

    // history addresses: entry base plus slot
    assign hist_base    = HIST_AW'(idx_reg) * HIST_AW'(HISTORY_DEPTH);
    assign hist_wr_addr = hist_base + HIST_AW'(entry_rd.ptr);
    assign hist_rd_addr = hist_base + HIST_AW'(nxt);

    // payload capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg      <= in_data.entry_index[ENTRY_AW-1:0];
            now_reg      <= in_data.arrival_sec;
            drop_reg     <= in_data.drop_allowed;
            in_range_reg <= in_range;
        end
        if (state_reg == psfd_pkg::FSM_HIST)
        begin
            rec_reg       <= entry_rd;
            nxt_reg       <= nxt;
            // slot s has been written once more than s beats were seen
            old_valid_reg <= entry_rd.count > psfd_pkg::CNT_W'(nxt);
        end
        if (out_load)
        begin
            if (in_range_reg)
            begin
                out_data_reg <= '{action: action_new, entry_status: status_new,
                                  packet_count: count_new};
            end
            else
            begin
                out_data_reg <= '0;
            end
        end
    end

    // flood test on the signed difference
    assign old_sec = old_valid_reg ? hist_rd : '0;
    assign diff    = {1'b0, now_reg} - {1'b0, old_sec};
    assign flood   = $signed(diff) < $signed({{(psfd_pkg::SEC_W + 1 - psfd_pkg::WINDOW_W){1'b0}},
                                               window_reg});

    assign count_new = (rec_reg.count == '1) ? rec_reg.count : rec_reg.count + 1'b1;

    // status escalation
    always_comb
    begin
        status_new = rec_reg.status;
        action_new = psfd_pkg::ACT_NONE;
        case (rec_reg.status)
            psfd_pkg::ST_CLEAR:
            begin
                if (flood)
                begin
                    status_new = psfd_pkg::ST_REJECTED;
                    action_new = psfd_pkg::ACT_REJECTED;
                end
            end
            psfd_pkg::ST_REJECTED:
            begin
                if (flood && drop_reg)
                begin
                    status_new = psfd_pkg::ST_DROPPED;
                    action_new = psfd_pkg::ACT_DROPPED;
                end
            end
            default:
            begin
                status_new = rec_reg.status;
            end
        endcase
    end

    assign entry_wr = '{ptr: nxt_reg, status: status_new, count: count_new};

    psfd_entry_store #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .AW          (ENTRY_AW)
    ) u_entry_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (entry_ctl),
        .rd_addr (in_data.entry_index[ENTRY_AW-1:0]),
        .wr_addr (idx_reg),
        .wr_data (entry_wr),
        .rd_data (entry_rd)
    );

    psfd_hist_ram #(
        .DEPTH (HIST_DEPTH),
        .AW    (HIST_AW)
    ) u_hist_ram (
        .clk     (clk),
        .ctl     (hist_ctl),
        .rd_addr (hist_rd_addr),
        .wr_addr (hist_wr_addr),
        .wr_data (now_reg),
        .rd_data (hist_rd)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[hw/rtl/psfd_checker.sv]
// psfd_checker: port-level assertions for per_source_flood_detector,
// bound to the top level; uses psfd_pkg codes

module psfd_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input psfd_pkg::out_beat_t out_data
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // one beat at a time: busy right after an accepted beat
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again before the previous beat finished");

    // newly rejected must report rejected status
    a_reject_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.action == psfd_pkg::ACT_REJECTED)
        |-> out_data.entry_status == psfd_pkg::ST_REJECTED)
        else $error("reject action with wrong status");

    // newly dropped must report dropped status
    a_drop_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.action == psfd_pkg::ACT_DROPPED)
        |-> out_data.entry_status == psfd_pkg::ST_DROPPED)
        else $error("drop action with wrong status");

endmodule

bind per_source_flood_detector psfd_checker u_psfd_checker (.*);

[tb/per_source_flood_detector_tb.sv]
// per_source_flood_detector_tb: self-checking bench for the per-source flood detector,
// predicts each result beat from a model of the entry rings, status and counts
// depends on psfd_pkg and per_source_flood_detector

module per_source_flood_detector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NUM_SOURCES  = 256;
    localparam int unsigned RING_DEPTH   = 50;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned LONG_HOLD    = 300;
    localparam int unsigned DRAIN_SLACK  = 12;
    localparam int unsigned NUM_PHASES   = 6;
    localparam int unsigned PHASE_ITEMS  = 240;
    localparam int unsigned POOL_SIZE    = 3;

    // scoreboard: per-source flood predictor and the queue of predicted beats
    class flood_scoreboard;
        logic [psfd_pkg::WINDOW_W-1:0] window;
        logic [psfd_pkg::SEC_W-1:0]    arrivals [NUM_SOURCES][RING_DEPTH];
        int unsigned                   ring_ptr [NUM_SOURCES];
        psfd_pkg::status_t             src_status [NUM_SOURCES];
        logic [psfd_pkg::CNT_W-1:0]    src_count [NUM_SOURCES];
        psfd_pkg::out_beat_t           expected_results [$];
        int                            errors;

        function new();
            window  = psfd_pkg::WINDOW_RESET;
            errors  = 0;
            foreach (arrivals[i, j])
                arrivals[i][j] = '0;
            foreach (ring_ptr[i])
            begin
                ring_ptr[i]   = 0;
                src_status[i] = psfd_pkg::ST_CLEAR;
                src_count[i]  = '0;
            end
        endfunction

        // one line per mismatch
        task report(string what);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        // accepted input beat: update the source entry and queue its result
        function void note_packet(psfd_pkg::in_beat_t beat);
            psfd_pkg::out_beat_t res;
            int unsigned         src;
            int unsigned         nxt;
            longint              span;
            res = '0;
            src = beat.entry_index;
            if (src < NUM_SOURCES)
            begin
                if (src_count[src] != '1)
                    src_count[src]++;
                nxt = (ring_ptr[src] + 1) % RING_DEPTH;
                arrivals[src][ring_ptr[src]] = beat.arrival_sec;
                // exact signed difference against the arrival one ring earlier
                span = longint'({1'b0, beat.arrival_sec}) - longint'({1'b0, arrivals[src][nxt]});
                res.action = psfd_pkg::ACT_NONE;
                if (span < longint'(window))
                begin
                    if (src_status[src] == psfd_pkg::ST_CLEAR)
                    begin
                        src_status[src] = psfd_pkg::ST_REJECTED;
                        res.action      = psfd_pkg::ACT_REJECTED;
                    end
                    else if (beat.drop_allowed && src_status[src] == psfd_pkg::ST_REJECTED)
                    begin
                        src_status[src] = psfd_pkg::ST_DROPPED;
                        res.action      = psfd_pkg::ACT_DROPPED;
                    end
                end
                ring_ptr[src]    = nxt;
                res.entry_status = src_status[src];
                res.packet_count = src_count[src];
            end
            expected_results.push_back(res);
        endfunction

        // accepted output beat: compare field by field with the oldest prediction
        task check_result(psfd_pkg::out_beat_t got);
            psfd_pkg::out_beat_t want;
            if (expected_results.size() == 0)
            begin
                report($sformatf("result beat %h with nothing pending", got));
                return;
            end
            want = expected_results.pop_front();
            if (got.action !== want.action)
                report($sformatf("action %0d, predicted %0d", got.action, want.action));
            if (got.entry_status !== want.entry_status)
                report($sformatf("entry_status %0d, predicted %0d",
                                 got.entry_status, want.entry_status));
            if (got.packet_count !== want.packet_count)
                report($sformatf("packet_count %0d, predicted %0d",
                                 got.packet_count, want.packet_count));
        endtask
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          window_wr_en;
    logic [psfd_pkg::WINDOW_W-1:0] window_wr_data;
    logic                          in_valid;
    logic                          in_stall;
    psfd_pkg::in_beat_t            in_data;
    logic                          out_valid;
    logic                          out_stall;
    psfd_pkg::out_beat_t           out_data;

    flood_scoreboard sb = new();
    int unsigned     cycle_count = 0;
    int unsigned     burst_left = 0;
    bit              long_hold_req = 1'b0;

    per_source_flood_detector #(
        .NUM_ENTRIES   (NUM_SOURCES),
        .HISTORY_DEPTH (RING_DEPTH)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .window_wr_en   (window_wr_en),
        .window_wr_data (window_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // beat monitor on both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_packet(in_data);
            if (out_valid && !out_stall)
                sb.check_result(out_data);
        end
    end

    // receiver: stall stretches of varying density, plus one long hold-off
    initial
    begin
        int unsigned stretch;
        int unsigned pct;
        int unsigned held;
        out_stall = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                held = 0;
                out_stall <= 1'b1;
                while (held < LONG_HOLD)
                begin
                    @(posedge clk);
                    held++;
                end
            end
            stretch = $urandom_range(20, 120);
            case ($urandom_range(0, 3))
                0:       pct = 0;
                1:       pct = 25;
                2:       pct = 50;
                default: pct = 80;
            endcase
            repeat (stretch)
            begin
                out_stall <= ($urandom_range(0, 99) < pct);
                @(posedge clk);
            end
        end
    end

    // offer one packet beat, then either keep the burst going or idle a while
    task automatic send_packet(input logic [psfd_pkg::IDX_W-1:0] idx,
                               input logic [psfd_pkg::SEC_W-1:0] sec,
                               input logic drop);
        psfd_pkg::in_beat_t beat;
        beat.entry_index  = idx;
        beat.arrival_sec  = sec;
        beat.drop_allowed = drop;
        in_data  <= beat;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
        else
            burst_left--;
    endtask

    // stop offering and wait for every predicted beat to come out
    task automatic drain();
        if (in_valid)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        while (sb.expected_results.size() != 0)
            @(posedge clk);
    endtask

    // window register write, only with the block idle
    task automatic set_window(input logic [psfd_pkg::WINDOW_W-1:0] value);
        drain();
        window_wr_data <= value;
        window_wr_en   <= 1'b1;
        @(posedge clk);
        window_wr_en <= 1'b0;
        sb.window = value;
    endtask

    // stimulus
    initial
    begin
        logic [psfd_pkg::IDX_W-1:0] pool_src [POOL_SIZE];
        logic [psfd_pkg::SEC_W-1:0] pool_time [POOL_SIZE];
        int unsigned                pool_step [POOL_SIZE];
        int unsigned                win;
        int unsigned                k;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        window_wr_en   = 1'b0;
        window_wr_data = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset window: early packets, escalation with and without permission
        send_packet(8'd0, 32'd0, 1'b0);
        send_packet(8'd0, 32'd0, 1'b0);
        send_packet(8'd0, 32'd1, 1'b1);
        send_packet(8'd0, 32'hFFFF_FFFF, 1'b1);
        send_packet(8'd255, 32'hFFFF_FFFF, 1'b0);
        send_packet(8'd255, 32'hFFFF_FFFF, 1'b1);
        send_packet(8'd1, 32'd3, 1'b1);
        send_packet(8'd2, 32'd2, 1'b1);
        send_packet(8'hAA, 32'hAAAA_AAAA, 1'b0);
        send_packet(8'h55, 32'h5555_5555, 1'b1);

        // zero window: equal times never count as a flood
        set_window('0);
        send_packet(8'd3, 32'd0, 1'b1);
        send_packet(8'd3, 32'd0, 1'b1);

        // widest window: boundary around the early-packet comparison
        set_window('1);
        send_packet(8'd4, 32'd65534, 1'b1);
        send_packet(8'd4, 32'd65535, 1'b1);
        send_packet(8'd5, 32'd65535, 1'b0);
        send_packet(8'd6, 32'h8000_0000, 1'b1);

        // random phases: a few sources with steady arrival rates, plus noise
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:       win = 0;
                1:       win = 16'hFFFF;
                2:       win = psfd_pkg::WINDOW_RESET;
                3:       win = $urandom_range(1, 100);
                4:       win = $urandom_range(100, 5000);
                default: win = $urandom_range(0, 65535);
            endcase
            set_window(win[psfd_pkg::WINDOW_W-1:0]);
            for (int p = 0; p < POOL_SIZE; p++)
            begin
                pool_src[p]  = psfd_pkg::IDX_W'($urandom_range(0, NUM_SOURCES - 1));
                pool_time[p] = $urandom;
                pool_step[p] = $urandom_range(0, (2 * win) / (RING_DEPTH - 1) + 2);
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 2 && n == 60)
                    long_hold_req = 1'b1;
                if (ph == 4 && n == 120)
                    drain();
                if ($urandom_range(0, 99) < 85)
                begin
                    k = $urandom_range(0, POOL_SIZE - 1);
                    // mostly forward in time, now and then a step back
                    if ($urandom_range(0, 99) < 3)
                        pool_time[k] = pool_time[k] - $urandom_range(1, 1000);
                    else
                        pool_time[k] = pool_time[k] + $urandom_range(0, pool_step[k]);
                    send_packet(pool_src[k], pool_time[k], 1'($urandom_range(0, 1)));
                end
                else
                    send_packet(psfd_pkg::IDX_W'($urandom_range(0, NUM_SOURCES - 1)),
                                $urandom, 1'($urandom_range(0, 1)));
            end
        end

        // wind down and make sure nothing stray follows
        drain();
        repeat (DRAIN_SLACK) @(posedge clk);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[files.f]
hw/rtl/psfd_pkg.sv
hw/rtl/psfd_entry_store.sv
hw/rtl/psfd_hist_ram.sv
hw/rtl/per_source_flood_detector.sv
hw/rtl/psfd_checker.sv
tb/per_source_flood_detector_tb.sv
